>>> src/serial_packet_deframer_defines.svh
// Assertion macros for the serial packet deframer
`ifndef SERIAL_PACKET_DEFRAMER_DEFINES_SVH
`define SERIAL_PACKET_DEFRAMER_DEFINES_SVH

// Check that cons holds in the same cycle as ante
`define SPD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer check failed");

// Check that cons holds in the cycle after ante
`define SPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

>>> src/spd_pkg.sv
// Types and constants for the serial packet deframer
`timescale 1ns / 1ps

package spd_pkg;

    typedef enum logic [3:0] {
        PH_HUNT0    = 4'd0,
        PH_HUNT1    = 4'd1,
        PH_LEN0     = 4'd2,
        PH_LEN1     = 4'd3,
        PH_BODY     = 4'd4,
        PH_CSUM0    = 4'd5,
        PH_CSUM1    = 4'd6,
        PH_TRL0     = 4'd7,
        PH_TRL1     = 4'd8,
        PH_SKIPBODY = 4'd9,
        PH_SKIP4    = 4'd10,
        PH_SKIP3    = 4'd11,
        PH_SKIP2    = 4'd12,
        PH_SKIP1    = 4'd13
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_NAK          = 3'd1,
        ST_BAD_HEADER   = 3'd2,
        ST_TOO_SHORT    = 3'd3,
        ST_BAD_TYPE     = 3'd4,
        ST_BAD_CHECKSUM = 3'd5,
        ST_BAD_TRAILER  = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        REG_EXPECTED_TYPE = 2'd0,
        REG_MIN_LENGTH    = 2'd1,
        REG_MAX_LENGTH    = 2'd2,
        REG_ACCEPT_NAK    = 2'd3
    } reg_index_t;

    localparam int unsigned SUM_W    = 15;
    localparam int unsigned PADDR_W  = 4;

    localparam logic [7:0]  HEADER_BYTE0 = 8'hA0;
    localparam logic [7:0]  HEADER_BYTE1 = 8'hA2;
    localparam logic [15:0] TRAILER_WORD = 16'hB3B0;
    localparam logic [7:0]  NAK_TYPE     = 8'h00;

    localparam logic [7:0]  RESET_EXPECTED_TYPE = 8'd3;
    localparam logic [15:0] RESET_MIN_LENGTH    = 16'd0;
    localparam logic [15:0] RESET_MAX_LENGTH    = 16'hFFFF;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        status_t     status_code;
        logic [15:0] payload_count;
        logic        last;
    } result_t;

endpackage

>>> src/spd_if.sv
// Stream interfaces for received bytes and deframer results
`timescale 1ns / 1ps

interface spd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface spd_result_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  payload_byte;
    logic [2:0]  status_code;
    logic [15:0] payload_count;
    logic        last;

    modport source (output valid, output kind, output payload_byte, output status_code,
                    output payload_count, output last, input ready);
    modport sink (input valid, input kind, input payload_byte, input status_code,
                  input payload_count, input last, output ready);
endinterface

>>> src/serial_packet_deframer.sv
// Serial packet deframer: byte stream in, payload bytes and frame status out
//
//   channel  | dir | handshake          | contents
//   ---------+-----+--------------------+------------------------------------------
//   rx       | in  | valid / ready      | rx_byte
//   frame    | out | valid / ready      | kind, payload_byte, status_code,
//            |     |                    | payload_count, last
//   apb      | in  | psel/penable/pwrite| expected_type, min_length, max_length,
//            |     |                    | accept_nak
//
// One item per cycle while the result is not stalled: a byte is held in the
// input register, then the parser updates its state and loads the result register.
// Reset clears the parser to header hunting and loads register defaults.
// A stalled result holds the result register; the input register takes an item
// while it is empty, or while the result register is empty or being drained.
`timescale 1ns / 1ps
`include "serial_packet_deframer_defines.svh"

module serial_packet_deframer
(
    input  logic                          clk,
    input  logic                          rst_n,
    spd_rx_if.sink                        rx,
    spd_result_if.source                  frame,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [spd_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic [7:0]  expected_type_reg;
    logic [15:0] min_length_reg;
    logic [15:0] max_length_reg;
    logic        accept_nak_reg;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg;
    spd_pkg::result_t out_data_reg;

    spd_pkg::phase_t             phase_reg,        phase_next;
    logic [15:0]                 frame_length_reg, frame_length_next;
    logic [15:0]                 byte_index_reg,   byte_index_next;
    logic [spd_pkg::SUM_W-1:0]   sum_reg,          sum_next;
    logic [7:0]                  csum_low_reg,     csum_low_next;
    logic [7:0]                  len_low_reg,      len_low_next;
    logic                        matched_reg,      matched_next;

    logic             advance;
    logic             fire;
    logic             emit;
    spd_pkg::result_t result;
    logic [15:0]      count;
    logic [15:0]      index_inc;
    logic [15:0]      new_length;
    logic [15:0]      word;
    logic             cfg_write;
    spd_pkg::reg_index_t cfg_sel;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_sel   = spd_pkg::reg_index_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_type_reg <= spd_pkg::RESET_EXPECTED_TYPE;
            min_length_reg    <= spd_pkg::RESET_MIN_LENGTH;
            max_length_reg    <= spd_pkg::RESET_MAX_LENGTH;
            accept_nak_reg    <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_sel)
                spd_pkg::REG_EXPECTED_TYPE: expected_type_reg <= pwdata[7:0];
                spd_pkg::REG_MIN_LENGTH:    min_length_reg    <= pwdata[15:0];
                spd_pkg::REG_MAX_LENGTH:    max_length_reg    <= pwdata[15:0];
                spd_pkg::REG_ACCEPT_NAK:    accept_nak_reg    <= pwdata[0];
                default:                    accept_nak_reg    <= accept_nak_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            spd_pkg::REG_EXPECTED_TYPE: prdata = {24'd0, expected_type_reg};
            spd_pkg::REG_MIN_LENGTH:    prdata = {16'd0, min_length_reg};
            spd_pkg::REG_MAX_LENGTH:    prdata = {16'd0, max_length_reg};
            spd_pkg::REG_ACCEPT_NAK:    prdata = {31'd0, accept_nak_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    // Pipeline control
    assign advance  = !out_valid_reg || frame.ready;
    assign rx.ready = !in_valid_reg || advance;
    assign fire     = in_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rx.ready)
            begin
                in_valid_reg <= rx.valid;
            end
            if (advance)
            begin
                out_valid_reg <= fire && emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
        begin
            in_byte_reg <= rx.rx_byte;
        end
        if (fire && emit)
        begin
            out_data_reg <= result;
        end
    end

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= spd_pkg::PH_HUNT0;
            frame_length_reg <= 16'd0;
            byte_index_reg   <= 16'd0;
            sum_reg          <= '0;
            csum_low_reg     <= 8'd0;
            len_low_reg      <= 8'd0;
            matched_reg      <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg        <= phase_next;
            frame_length_reg <= frame_length_next;
            byte_index_reg   <= byte_index_next;
            sum_reg          <= sum_next;
            csum_low_reg     <= csum_low_next;
            len_low_reg      <= len_low_next;
            matched_reg      <= matched_next;
        end
    end

    assign count      = frame_length_reg - 16'd1;
    assign index_inc  = byte_index_reg + 16'd1;
    assign new_length = {in_byte_reg, len_low_reg};
    assign word       = {in_byte_reg, csum_low_reg};

    always_comb
    begin
        phase_next        = phase_reg;
        frame_length_next = frame_length_reg;
        byte_index_next   = byte_index_reg;
        sum_next          = sum_reg;
        csum_low_next     = csum_low_reg;
        len_low_next      = len_low_reg;
        matched_next      = matched_reg;
        emit                 = 1'b0;
        result.kind          = 1'b1;
        result.payload_byte  = 8'd0;
        result.status_code   = spd_pkg::ST_OK;
        result.payload_count = 16'd0;
        result.last          = 1'b1;

        unique case (phase_reg)
            spd_pkg::PH_HUNT1:
            begin
                if (in_byte_reg == spd_pkg::HEADER_BYTE1)
                begin
                    phase_next = spd_pkg::PH_LEN0;
                end
                else
                begin
                    phase_next         = spd_pkg::PH_HUNT0;
                    emit               = 1'b1;
                    result.status_code = spd_pkg::ST_BAD_HEADER;
                end
            end
            spd_pkg::PH_LEN0:
            begin
                len_low_next = in_byte_reg;
                phase_next   = spd_pkg::PH_LEN1;
            end
            spd_pkg::PH_LEN1:
            begin
                frame_length_next = new_length;
                byte_index_next   = 16'd0;
                sum_next          = '0;
                matched_next      = 1'b0;
                if (new_length <= min_length_reg)
                begin
                    phase_next         = spd_pkg::PH_HUNT0;
                    emit               = 1'b1;
                    result.status_code = spd_pkg::ST_TOO_SHORT;
                end
                else
                begin
                    phase_next = spd_pkg::PH_BODY;
                end
            end
            spd_pkg::PH_BODY:
            begin
                sum_next        = sum_reg + spd_pkg::SUM_W'(in_byte_reg);
                byte_index_next = index_inc;
                if (byte_index_reg == 16'd0 && in_byte_reg != expected_type_reg)
                begin
                    // Wrong type: report now, skip the rest of the frame
                    emit                 = 1'b1;
                    result.payload_count = count;
                    result.status_code   = (accept_nak_reg && in_byte_reg == spd_pkg::NAK_TYPE)
                                           ? spd_pkg::ST_NAK : spd_pkg::ST_BAD_TYPE;
                    phase_next = (index_inc == frame_length_reg) ? spd_pkg::PH_SKIP4
                                                                 : spd_pkg::PH_SKIPBODY;
                end
                else
                begin
                    if (index_inc == frame_length_reg)
                    begin
                        phase_next = spd_pkg::PH_CSUM0;
                    end
                    if (byte_index_reg != 16'd0 && byte_index_reg <= max_length_reg)
                    begin
                        emit                = 1'b1;
                        result.kind         = 1'b0;
                        result.payload_byte = in_byte_reg;
                        result.last         = 1'b0;
                    end
                end
            end
            spd_pkg::PH_CSUM0:
            begin
                csum_low_next = in_byte_reg;
                phase_next    = spd_pkg::PH_CSUM1;
            end
            spd_pkg::PH_CSUM1:
            begin
                if (word != {1'b0, sum_reg})
                begin
                    phase_next           = spd_pkg::PH_SKIP2;
                    emit                 = 1'b1;
                    result.status_code   = spd_pkg::ST_BAD_CHECKSUM;
                    result.payload_count = count;
                end
                else
                begin
                    matched_next = 1'b1;
                    phase_next   = spd_pkg::PH_TRL0;
                end
            end
            spd_pkg::PH_TRL0:
            begin
                csum_low_next = in_byte_reg;
                phase_next    = spd_pkg::PH_TRL1;
            end
            spd_pkg::PH_TRL1:
            begin
                phase_next           = spd_pkg::PH_HUNT0;
                emit                 = 1'b1;
                result.payload_count = count;
                result.status_code   = (word == spd_pkg::TRAILER_WORD && matched_reg)
                                       ? spd_pkg::ST_OK : spd_pkg::ST_BAD_TRAILER;
            end
            spd_pkg::PH_SKIPBODY:
            begin
                byte_index_next = index_inc;
                if (index_inc == frame_length_reg)
                begin
                    phase_next = spd_pkg::PH_SKIP4;
                end
            end
            spd_pkg::PH_SKIP4: phase_next = spd_pkg::PH_SKIP3;
            spd_pkg::PH_SKIP3: phase_next = spd_pkg::PH_SKIP2;
            spd_pkg::PH_SKIP2: phase_next = spd_pkg::PH_SKIP1;
            spd_pkg::PH_SKIP1: phase_next = spd_pkg::PH_HUNT0;
            default:
            begin
                if (in_byte_reg == spd_pkg::HEADER_BYTE0)
                begin
                    phase_next = spd_pkg::PH_HUNT1;
                end
                else
                begin
                    phase_next         = spd_pkg::PH_HUNT0;
                    emit               = 1'b1;
                    result.status_code = spd_pkg::ST_BAD_HEADER;
                end
            end
        endcase
    end

    assign frame.valid         = out_valid_reg;
    assign frame.kind          = out_data_reg.kind;
    assign frame.payload_byte  = out_data_reg.payload_byte;
    assign frame.status_code   = out_data_reg.status_code;
    assign frame.payload_count = out_data_reg.payload_count;
    assign frame.last          = out_data_reg.last;

    `SPD_ASSERT_NOW(a_body_length_nonzero, clk, rst_n,
        phase_reg == spd_pkg::PH_BODY || phase_reg == spd_pkg::PH_SKIPBODY,
        frame_length_reg != 16'd0)
    `SPD_ASSERT_NOW(a_header_status_no_count, clk, rst_n,
        out_valid_reg && out_data_reg.kind &&
        (out_data_reg.status_code == spd_pkg::ST_BAD_HEADER ||
         out_data_reg.status_code == spd_pkg::ST_TOO_SHORT),
        out_data_reg.payload_count == 16'd0)
    `SPD_ASSERT_NEXT(a_input_held_on_stall, clk, rst_n,
        in_valid_reg && !advance,
        in_valid_reg && $stable(in_byte_reg))

endmodule
